[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Plain invariant checked on every rising clock edge.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

[rtl/tcpq_pkg.sv]
// ----------------------------------------------------------------------------
// tcpq_pkg
// Types and constants of the two-class priority job queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int QueueDepthDefault = 32;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;
  localparam logic [1:0] OP_CANCEL  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] job_id;
    logic [15:0] page_count;
    logic [15:0] document_tag;
    logic        is_priority;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [15:0] out_pages;
    logic [15:0] out_tag;
    logic        from_priority;
  } out_word_t;

  // One stored job.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pages;
    logic [15:0] tag;
  } job_t;

endpackage

[rtl/two_class_priority_job_queue.sv]
// ----------------------------------------------------------------------------
// two_class_priority_job_queue
// Strict-priority pair of job FIFOs with duplicate check, search and cancel.
// ----------------------------------------------------------------------------
// Each command word is accepted when start is high and busy is low, and gives
// exactly one result word, shown for one cycle with out_valid high; the
// receiver cannot stall it. The result word appears in the first cycle in
// which busy is low again. Jobs live in two single-port-read memories, one
// per queue, and every scan reads one slot per cycle. A dequeue reads the
// head slot and then takes the job. An insert scans both queues for a
// duplicate id, a search scans until it hits or both queues are exhausted,
// and a cancel scans and then shifts the tail one slot per cycle. The worst
// case is a cancel that finds the oldest priority job behind a full normal
// queue in a full priority queue, which keeps busy high the longest.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_class_priority_job_queue
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(QUEUE_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // issue reads of a queue
  localparam logic [2:0] S_DEQ   = 3'd2;  // read head slot
  localparam logic [2:0] S_SHIFT = 3'd3;  // close gap after cancel
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  in_word_t      cmd_r, cmd_nxt;
  logic [AW-1:0] head_r [2];
  logic [AW-1:0] head_nxt [2];
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic          q_r, q_nxt;        // queue being scanned: 1 priority
  logic          pass_r, pass_nxt;  // second queue of the scan
  logic [CW-1:0] pos_r, pos_nxt;    // next position to read
  logic          rv_r, rv_nxt;      // read data valid next cycle
  logic [CW-1:0] rpos_r, rpos_nxt;  // position of the data in flight
  out_word_t     res_r, res_nxt;
  logic          ov_r, ov_nxt;

  logic [AW-1:0] raddr, waddr;
  logic          we [2];
  job_t          rdata [2];
  job_t          wdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(p);
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  for (genvar g = 0; g < 2; g++) begin : g_q
    tcpq_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
      .clk  (clk),
      .we   (we[g]),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata[g])
    );
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word  = res_r;

  job_t rd;
  assign rd = q_r ? rdata[1] : rdata[0];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    pass_nxt  = pass_r;
    pos_nxt   = pos_r;
    rv_nxt    = 1'b0;
    rpos_nxt  = pos_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    raddr     = slot(head_r[q_r], pos_r);
    waddr     = slot(head_r[q_r], rpos_r - CW'(1));
    wdata     = rd;
    we[0]     = 1'b0;
    we[1]     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_word;
          pos_nxt  = '0;
          pass_nxt = 1'b0;
          res_nxt  = '0;
          case (in_word.operation)
            OP_DEQUEUE: begin
              q_nxt     = (cnt_r[1] != '0);
              state_nxt = S_DEQ;
            end
            OP_SEARCH: begin
              q_nxt     = 1'b1;
              state_nxt = S_SCAN;
            end
            default: begin  // insert and cancel scan normal first
              q_nxt     = 1'b0;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_DEQ: begin
        raddr = head_r[q_r];
        if (cnt_r[q_r] == '0) begin
          res_nxt.status = ST_EMPTY;
          state_nxt = S_DONE;
        end else begin
          rv_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        // Check data that arrived from the previous read.
        if (rv_r && rd.id == cmd_r.job_id) begin
          if (cmd_r.operation == OP_INSERT) begin
            res_nxt.status = ST_DUP;
            state_nxt = S_DONE;
          end else begin
            res_nxt.status        = ST_OK;
            res_nxt.out_id        = rd.id;
            res_nxt.out_pages     = rd.pages;
            res_nxt.out_tag       = rd.tag;
            res_nxt.from_priority = q_r;
            if (cmd_r.operation == OP_CANCEL) begin
              pos_nxt   = rpos_r + CW'(1);
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end else if (pos_r < cnt_r[q_r]) begin
          rv_nxt  = 1'b1;
          pos_nxt = pos_r + CW'(1);
        end else if (!rv_r || pos_r == cnt_r[q_r]) begin
          // Nothing in flight still to check: this queue is exhausted.
          if (!pass_r) begin
            pass_nxt = 1'b1;
            q_nxt    = ~q_r;
            pos_nxt  = '0;
          end else if (cmd_r.operation == OP_INSERT) begin
            if (cnt_r[cmd_r.is_priority] >= DEPTH_C) begin
              res_nxt.status = ST_FULL;
            end else begin
              res_nxt.status = ST_OK;
              waddr = slot(head_r[cmd_r.is_priority], cnt_r[cmd_r.is_priority]);
              wdata = '{id: cmd_r.job_id, pages: cmd_r.page_count,
                        tag: cmd_r.document_tag};
              we[cmd_r.is_priority] = 1'b1;
              cnt_nxt[cmd_r.is_priority] = cnt_r[cmd_r.is_priority] + CW'(1);
            end
            state_nxt = S_DONE;
          end else begin
            res_nxt.status = ST_MISSING;
            state_nxt = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // Read position pos_r, then write it one slot nearer the head.
        if (rv_r) begin
          we[q_r] = 1'b1;
        end
        if (pos_r < cnt_r[q_r]) begin
          rv_nxt  = 1'b1;
          pos_nxt = pos_r + CW'(1);
        end else if (!rv_r) begin
          cnt_nxt[q_r] = cnt_r[q_r] - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (cmd_r.operation == OP_DEQUEUE && res_r.status != ST_EMPTY) begin
          res_nxt.status        = ST_OK;
          res_nxt.out_id        = rd.id;
          res_nxt.out_pages     = rd.pages;
          res_nxt.out_tag       = rd.tag;
          res_nxt.from_priority = q_r;
          head_nxt[q_r] = slot(head_r[q_r], CW'(1));
          cnt_nxt[q_r]  = cnt_r[q_r] - CW'(1);
        end
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r[0] <= '0;
      head_r[1] <= '0;
      cnt_r[0]  <= '0;
      cnt_r[1]  <= '0;
      rv_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r  <= cmd_nxt;
    q_r    <= q_nxt;
    pass_r <= pass_nxt;
    pos_r  <= pos_nxt;
    rpos_r <= rpos_nxt;
    res_r  <= res_nxt;
  end

  // A result is shown in the cycle after the sequencer is in S_DONE.
  `ASSERT_IMPL(a_result_after_done, clk, rst_n, (state_r == S_DONE) |=> out_valid, "result lost")
  // Queue occupancy never exceeds the depth.
  `ASSERT_IMPL(a_count_bound, clk, rst_n, (cnt_r[0] <= DEPTH_C) && (cnt_r[1] <= DEPTH_C), "count overflow")
  // The sequencer is idle whenever a result is being shown.
  `ASSERT_IMPL(a_valid_idle, clk, rst_n, out_valid |-> (state_r == S_IDLE), "result while busy")

endmodule

[rtl/tcpq_ram.sv]
// ----------------------------------------------------------------------------
// tcpq_ram
// Job store of one queue: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcpq_ram
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  job_t          wdata,
  input  logic [AW-1:0] raddr,
  output job_t          rdata
);

  job_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/sv/two_class_priority_job_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_priority_job_queue_tb
// Drives insert, dequeue, search and cancel command words into the job
// queue, predicts each result word with a behavioral model of the two
// priority classes, and checks every result word field by field.
// ----------------------------------------------------------------------------

module two_class_priority_job_queue_tb;
  import tcpq_pkg::*;

  localparam int Depth      = 32;
  localparam int WatchLimit = 20000;
  localparam int NumRandom  = 1830;

  // Scoreboard: a behavioral copy of both job FIFOs plus the list of result
  // words still owed by the block.
  class job_queue_scoreboard;
    job_t      prio_jobs[$];
    job_t      norm_jobs[$];
    out_word_t owed[$];
    int        mismatches;

    function automatic int find_id(ref job_t q[$], input logic [15:0] id);
      for (int i = 0; i < q.size(); i++) begin
        if (q[i].id == id) return i;
      end
      return -1;
    endfunction

    // Work out the result of one accepted command word and update the model.
    function void note_command(in_word_t w);
      out_word_t r;
      int        p;
      r = '0;
      case (w.operation)
        OP_INSERT: begin
          if (find_id(norm_jobs, w.job_id) >= 0 || find_id(prio_jobs, w.job_id) >= 0) begin
            r.status = ST_DUP;
          end else if ((w.is_priority ? prio_jobs.size() : norm_jobs.size()) >= Depth) begin
            r.status = ST_FULL;
          end else begin
            if (w.is_priority) prio_jobs.push_back({w.job_id, w.page_count, w.document_tag});
            else norm_jobs.push_back({w.job_id, w.page_count, w.document_tag});
            r.status = ST_OK;
          end
        end
        OP_DEQUEUE: begin
          if (prio_jobs.size() > 0) begin
            r = {ST_OK, prio_jobs[0], 1'b1};
            void'(prio_jobs.pop_front());
          end else if (norm_jobs.size() > 0) begin
            r = {ST_OK, norm_jobs[0], 1'b0};
            void'(norm_jobs.pop_front());
          end else begin
            r.status = ST_EMPTY;
          end
        end
        OP_SEARCH: begin
          p = find_id(prio_jobs, w.job_id);
          if (p >= 0) r = {ST_OK, prio_jobs[p], 1'b1};
          else begin
            p = find_id(norm_jobs, w.job_id);
            if (p >= 0) r = {ST_OK, norm_jobs[p], 1'b0};
            else r.status = ST_MISSING;
          end
        end
        default: begin
          // Cancel looks in the normal FIFO first, unlike search.
          p = find_id(norm_jobs, w.job_id);
          if (p >= 0) begin
            r = {ST_OK, norm_jobs[p], 1'b0};
            norm_jobs.delete(p);
          end else begin
            p = find_id(prio_jobs, w.job_id);
            if (p >= 0) begin
              r = {ST_OK, prio_jobs[p], 1'b1};
              prio_jobs.delete(p);
            end else r.status = ST_MISSING;
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.out_id !== want.out_id ||
          got.out_pages !== want.out_pages || got.out_tag !== want.out_tag ||
          got.from_priority !== want.from_priority) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected st=%0d id=%h pg=%h tag=%h pr=%b, ",
                    "got st=%0d id=%h pg=%h tag=%h pr=%b"},
                   want.status, want.out_id, want.out_pages, want.out_tag, want.from_priority,
                   got.status, got.out_id, got.out_pages, got.out_tag, got.from_priority);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  job_queue_scoreboard board = new();
  int  idle_cycles = 0;
  bit  calm = 1'b0;   // set for the last part of the run: no gaps between words
  logic [15:0] used_ids[$];

  always #4 clk = ~clk;

  two_class_priority_job_queue i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  // Acceptance and result checking happen at the rising edge only.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_command(in_word);
      end
      if (out_valid) begin
        board.check_result(out_word);
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("[two_class_priority_job_queue] ERROR");
        $finish;
      end
    end
  end

  // Present one command word at the falling edge and hold it until accepted.
  // Between words the sender sometimes pauses for a short burst.
  task automatic send_word(logic [1:0] op, logic [15:0] id, logic [15:0] pages,
                           logic [15:0] tag, logic prio);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= '{operation: op, job_id: id, page_count: pages,
                 document_tag: tag, is_priority: prio};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Ids come mostly from a small pool, so duplicates, hits and cancels occur.
  function automatic logic [15:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(0, 9) < 7)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    pick_id = 16'($urandom);
    if (used_ids.size() < 48) used_ids.push_back(pick_id);
  endfunction

  initial begin
    int burst;
    logic [1:0] op;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty dequeue, missing search and cancel, field extremes,
    // duplicate id, a full priority FIFO, then order-keeping cancel.
    send_word(OP_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_SEARCH, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_CANCEL, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_INSERT, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_word(OP_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    send_word(OP_INSERT, 16'hFFFF, 16'h1234, 16'h5678, 1'b0);
    send_word(OP_SEARCH, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_word(OP_SEARCH, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    for (int i = 0; i < Depth + 1; i++)
      send_word(OP_INSERT, 16'(16'h0100 + i), 16'(i), 16'(~i), 1'b1);
    send_word(OP_INSERT, 16'h0200, 16'h0001, 16'h0002, 1'b0);
    send_word(OP_CANCEL, 16'h0105, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_CANCEL, 16'h0200, 16'h0000, 16'h0000, 1'b1);
    for (int i = 0; i < Depth; i++)
      send_word(OP_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0);

    // Random part: bursts that lean toward filling, then toward draining, so
    // both FIFOs run between empty and full and wrap their heads.
    for (int n = 0; n < NumRandom; n++) begin
      if (n >= NumRandom - 200) calm = 1'b1;
      burst = (n / 120) % 2;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = burst ? OP_DEQUEUE : OP_INSERT;
        4, 5:       op = OP_INSERT;
        6:          op = OP_DEQUEUE;
        7:          op = OP_SEARCH;
        default:    op = OP_CANCEL;
      endcase
      send_word(op, pick_id(), 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      if (used_ids.size() >= 48 && $urandom_range(0, 40) == 0) used_ids.delete(0);
    end
    @(negedge clk);
    start <= 1'b0;

    while (board.owed.size() > 0) @(posedge clk);
    repeat (2 * Depth + 10) @(posedge clk);
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("[two_class_priority_job_queue] OK");
    end else begin
      $display("[two_class_priority_job_queue] ERROR");
    end
    $finish;
  end

endmodule
